// File: hdl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/hdrr_pkg.sv
// types, constants and the percent table of the rate-of-rise scaler
package hdrr_pkg;

  localparam int DETECTORS = 256;
  localparam int WINDOW    = 8;
  localparam int DET_AW    = $clog2(DETECTORS);
  localparam int ROW_W     = WINDOW * 8;
  localparam int PROD_W    = 15;
  localparam int RECIP_SH  = 19;

  localparam logic [7:0] TYPE_HEAT    = 8'h44;
  localparam logic [7:0] TYPE_PASS_LO = 8'h40;
  localparam logic [7:0] TYPE_PASS_HI = 8'h43;
  localparam logic [7:0] HOT_RESET    = 8'd65;

  // floor(x / 100) == (x * RECIP) >> RECIP_SH for x below 2^15
  localparam logic [12:0]       RECIP     = 13'd5243;
  localparam logic [PROD_W-1:0] SAT_LIMIT = 15'd25600;

  localparam logic [6:0] PCT_RISE5_HOT = 7'd107;
  localparam logic [6:0] PCT_RISE5     = 7'd108;
  localparam logic [6:0] PCT_RISE4     = 7'd106;
  localparam logic [6:0] PCT_RISE3     = 7'd104;
  localparam logic [6:0] PCT_RISE2     = 7'd100;
  localparam logic [6:0] PCT_RISE1     = 7'd96;
  localparam logic [6:0] PCT_FLAT      = 7'd92;

  typedef enum logic [1:0] {
    KIND_SCALE,
    KIND_PASS,
    KIND_HOLD
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        value;
    logic [PROD_W-1:0] prod;
  } scale_req_t;

  function automatic logic [6:0] pick_percent(logic signed [8:0] rise,
                                              logic [7:0] newest,
                                              logic [7:0] hot);
    logic [6:0] pct;
    if (rise >= 9'sd5) begin
      pct = (newest > hot) ? PCT_RISE5_HOT : PCT_RISE5;
    end else if (rise == 9'sd4) begin
      pct = PCT_RISE4;
    end else if (rise == 9'sd3) begin
      pct = PCT_RISE3;
    end else if (rise == 9'sd2) begin
      pct = PCT_RISE2;
    end else if (rise == 9'sd1) begin
      pct = PCT_RISE1;
    end else begin
      pct = PCT_FLAT;
    end
    return pct;
  endfunction

endpackage

// File: hdl/hdrr_hist_ram.sv
// window history memory, one row per detector, with per-row valid bits
module hdrr_hist_ram
  import hdrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [DET_AW-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_row,
  output logic              rd_vld,
  input  logic              wr_en,
  input  logic [DET_AW-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_row
);

  logic [ROW_W-1:0]     mem [DETECTORS];
  logic [DETECTORS-1:0] vld_r;
  logic [ROW_W-1:0]     rd_row_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_row = rd_row_r;
  assign rd_vld = rd_vld_r;

endmodule

// File: hdl/hdrr_window.sv
// window update, rise classification and percent multiply
module hdrr_window
  import hdrr_pkg::*;
(
  input  logic [7:0]       req_type,
  input  logic [7:0]       sample,
  input  logic [7:0]       hot_level,
  input  logic [ROW_W-1:0] rd_row,
  input  logic             rd_vld,
  input  logic             fwd_hit,
  input  logic [ROW_W-1:0] fwd_row,
  output logic [ROW_W-1:0] new_row,
  output scale_req_t       req
);

  logic [ROW_W-1:0] cur_row;
  logic [7:0]       oldest;
  logic signed [8:0] rise;
  logic [6:0]       pct;

  always_comb begin
    if (fwd_hit) begin
      cur_row = fwd_row;
    end else if (rd_vld) begin
      cur_row = rd_row;
    end else begin
      cur_row = '0;
    end
    new_row = {sample, cur_row[ROW_W-1:8]};
    oldest  = new_row[7:0];
    rise    = $signed({1'b0, sample}) - $signed({1'b0, oldest});
    pct     = pick_percent(rise, sample, hot_level);

    req.value = sample;
    req.prod  = PROD_W'({7'b0, sample} * {8'b0, pct});
    if (req_type == TYPE_HEAT) begin
      req.kind = (oldest == 8'd0) ? KIND_PASS : KIND_SCALE;
    end else if (req_type >= TYPE_PASS_LO && req_type <= TYPE_PASS_HI) begin
      req.kind = KIND_PASS;
    end else begin
      req.kind = KIND_HOLD;
    end
  end

endmodule

// File: hdl/hdrr_scale.sv
// divide by one hundred, saturate and pick the result
module hdrr_scale
  import hdrr_pkg::*;
(
  input  scale_req_t req,
  input  logic [7:0] last_result,
  output logic [7:0] result
);

  logic [27:0] q_full;
  logic        sat;

  always_comb begin
    q_full = 28'(req.prod) * 28'(RECIP);
    sat    = (req.prod >= SAT_LIMIT);
    case (req.kind)
      KIND_SCALE: result = sat ? 8'hFF : q_full[RECIP_SH+7:RECIP_SH];
      KIND_PASS:  result = req.value;
      default:    result = last_result;
    endcase
  end

endmodule

// File: hdl/heat_detector_rate_of_rise_scaler.sv
// top level of the heat detector rate-of-rise scaler
//
// input beats carry a type code, a detector number and a raw sample; every
// beat gives exactly one output beat, in order. analog heat beats shift the
// sample into that detector's eight-reading window, held as one row per
// detector in a single-port-read, single-port-write memory, and scale it by
// the percentage the window's rise selects (saturating at 255; while the
// oldest reading is zero the sample passes). pass types return the sample,
// other types repeat the previous result. one beat is taken every cycle
// until a stalled output backs the pipeline up: the window row is read at
// acceptance, rewritten as the beat leaves the first stage, and the last
// write is forwarded so back-to-back beats for the same detector see their own update.
// reset clears the per-row valid bits (an unwritten row reads as zero), the
// previous result and the pipeline, and loads hot_level with 65. cfg_wr_en
// writes hot_level. when out_ready is low the output holds and the first and
// second stages keep filling before in_ready drops.
module heat_detector_rate_of_rise_scaler
  import hdrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_req_type,
  input  logic [7:0] in_detector_index,
  input  logic [7:0] in_sample,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_result,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0]        hot_r;
  logic              s1_vld_r;
  logic [7:0]        s1_type_r;
  logic [DET_AW-1:0] s1_det_r;
  logic [7:0]        s1_smp_r;
  logic              s2_vld_r;
  scale_req_t        s2_req_r;
  logic              out_vld_r;
  logic [7:0]        out_res_r;
  logic              fwd_vld_r;
  logic [DET_AW-1:0] fwd_det_r;
  logic [ROW_W-1:0]  fwd_row_r;

  logic              s2_adv;
  logic              s1_adv;
  logic              in_acc;
  logic              wr_en;
  logic              fwd_hit;
  logic [ROW_W-1:0]  rd_row;
  logic              rd_vld;
  logic [ROW_W-1:0]  new_row;
  scale_req_t        s1_req;
  logic [7:0]        s2_res;

  assign s2_adv   = !out_vld_r || out_ready;
  assign s1_adv   = !s2_vld_r || s2_adv;
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = s1_vld_r && s1_adv && (s1_type_r == TYPE_HEAT);
  assign fwd_hit  = fwd_vld_r && (fwd_det_r == s1_det_r);

  hdrr_hist_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_detector_index[DET_AW-1:0]),
    .rd_row  (rd_row),
    .rd_vld  (rd_vld),
    .wr_en   (wr_en),
    .wr_addr (s1_det_r),
    .wr_row  (new_row)
  );

  hdrr_window u_window (
    .req_type  (s1_type_r),
    .sample    (s1_smp_r),
    .hot_level (hot_r),
    .rd_row    (rd_row),
    .rd_vld    (rd_vld),
    .fwd_hit   (fwd_hit),
    .fwd_row   (fwd_row_r),
    .new_row   (new_row),
    .req       (s1_req)
  );

  hdrr_scale u_scale (
    .req         (s2_req_r),
    .last_result (out_res_r),
    .result      (s2_res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_r     <= HOT_RESET;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      out_res_r <= 8'd0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hot_r <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (s1_adv) begin
        s2_vld_r <= s1_vld_r;
      end
      if (s2_adv) begin
        out_vld_r <= s2_vld_r;
        if (s2_vld_r) begin
          out_res_r <= s2_res;
        end
      end
      if (wr_en) begin
        fwd_vld_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_type_r <= in_req_type;
      s1_det_r  <= in_detector_index[DET_AW-1:0];
      s1_smp_r  <= in_sample;
    end
    if (s1_adv) begin
      s2_req_r <= s1_req;
    end
    if (wr_en) begin
      fwd_det_r <= s1_det_r;
      fwd_row_r <= new_row;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_result = out_res_r;

endmodule

// File: hdl/hdrr_checker.sv
// port-level checker for the rate-of-rise scaler, bound to the top level
`include "assert_macros.svh"

module hdrr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_result
);

  // a stalled output beat holds
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_result), "output beat changed while stalled")

  // input back-pressure only when the output is stalled
  `ASSERT_CLK(a_bp_cause, !in_ready |-> out_valid && !out_ready, "in_ready low without output stall")

  // reset empties the pipeline
  `ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid && in_ready, "pipeline not empty after reset")

  // an empty pipeline cannot hold back input
  `ASSERT_CLK(a_ready_idle, !out_valid && !$past(in_valid) |-> in_ready, "input stalled while idle")

endmodule

bind heat_detector_rate_of_rise_scaler hdrr_checker u_hdrr_checker (.*);

// File: sim/hdrr_checker.sv
`timescale 1ns / 1ps
// checker for the rate-of-rise scaler: predicts every result beat and compares it
module hdrr_scoreboard
  import hdrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_req_type,
  input  logic [7:0] in_detector_index,
  input  logic [7:0] in_sample,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_result,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output int         fail_count,
  output int         pending
);

  localparam int STEEP_HOT_PCT = 107;
  localparam int STEEP_PCT     = 108;
  localparam int RISE4_PCT     = 106;
  localparam int RISE3_PCT     = 104;
  localparam int RISE2_PCT     = 100;
  localparam int RISE1_PCT     = 96;
  localparam int FLAT_PCT      = 92;

  logic [7:0] window_mem [DETECTORS][WINDOW];
  logic [7:0] prev_reading;
  logic [7:0] hot_level;
  logic [7:0] reading_q [$];
  logic [7:0] want;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp_val);
    $display("mismatch: %s, got %0d, expected %0d, at %0t", what, got, exp_val, $time);
    fail_count++;
  endtask

  function automatic logic [7:0] next_reading(logic [7:0] kind, logic [7:0] det,
                                              logic [7:0] smp);
    int row;
    int rise;
    int pct;
    int scaled;
    row = int'(det) % DETECTORS;
    if (kind == TYPE_HEAT) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        window_mem[row][i] = window_mem[row][i + 1];
      end
      window_mem[row][WINDOW - 1] = smp;
      if (window_mem[row][0] == 8'd0) begin
        prev_reading = smp;
      end else begin
        rise = int'(smp) - int'(window_mem[row][0]);
        if (rise >= 5) begin
          pct = (smp > hot_level) ? STEEP_HOT_PCT : STEEP_PCT;
        end else if (rise == 4) begin
          pct = RISE4_PCT;
        end else if (rise == 3) begin
          pct = RISE3_PCT;
        end else if (rise == 2) begin
          pct = RISE2_PCT;
        end else if (rise == 1) begin
          pct = RISE1_PCT;
        end else begin
          pct = FLAT_PCT;
        end
        scaled = int'(smp) * pct / 100;
        prev_reading = (scaled > 255) ? 8'd255 : scaled[7:0];
      end
    end else if (kind >= TYPE_PASS_LO && kind <= TYPE_PASS_HI) begin
      prev_reading = smp;
    end
    return prev_reading;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DETECTORS; d++) begin
        for (int w = 0; w < WINDOW; w++) begin
          window_mem[d][w] = 8'd0;
        end
      end
      prev_reading = 8'd0;
      hot_level = HOT_RESET;
      reading_q.delete();
    end else begin
      if (cfg_wr_en) begin
        hot_level = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          report_mismatch("result beat with none expected", out_result, 8'hxx);
        end else begin
          want = reading_q.pop_front();
          if (out_result !== want) begin
            report_mismatch("result", out_result, want);
          end
        end
      end
      if (in_valid && in_ready) begin
        reading_q.push_back(next_reading(in_req_type, in_detector_index, in_sample));
      end
    end
    pending <= reading_q.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// stimulus, reset, watchdog and verdict for the rate-of-rise scaler
module tb;
  import hdrr_pkg::*;

  localparam logic [7:0] TYPE_HOLD_MIN = 8'h00;
  localparam logic [7:0] TYPE_HOLD_MAX = 8'hFF;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 10;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_req_type = 8'd0;
  logic [7:0] in_detector_index = 8'd0;
  logic [7:0] in_sample = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_result;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  int fail_count;
  int pending;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int quiet_cycles = 0;

  heat_detector_rate_of_rise_scaler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_detector_index (in_detector_index),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result        (out_result),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  hdrr_scoreboard u_scoreboard (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_detector_index (in_detector_index),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result        (out_result),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[heat_detector_rate_of_rise_scaler] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(logic [7:0] kind, logic [7:0] det, logic [7:0] smp);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_detector_index <= det;
    in_sample <= smp;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // let every expected result arrive with the input idle, then wait SETTLE_CYCLES
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hot_level(logic [7:0] level);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= level;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_segment(int n);
    int sent;
    int k;
    int det;
    int len;
    int base;
    int trend;
    int spread;
    int v;
    logic [7:0] kind;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 60) begin
        // run on one detector's window, with stray beats mixed in
        k = $urandom_range(0, 7);
        det = (k == 7) ? 255 : k * 37;
        len = $urandom_range(8, 20);
        k = $urandom_range(0, 9);
        base = (k == 0) ? 0 : (k < 3) ? $urandom_range(230, 252) : $urandom_range(1, 255);
        trend = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        k = $urandom_range(0, 4);
        spread = (k == 4) ? 6 : k;
        for (int j = 0; j < len; j++) begin
          k = $urandom_range(0, 19);
          if (k == 0) begin
            send_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
          end else if (k == 1) begin
            send_beat(TYPE_HEAT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end else begin
            v = base + j * trend + $urandom_range(0, spread);
            if (v > 255) v = 255;
            send_beat(TYPE_HEAT, 8'(det), 8'(v));
          end
          sent++;
        end
      end else begin
        k = $urandom_range(0, 3);
        if (k == 0) begin
          kind = TYPE_PASS_LO + 8'($urandom_range(0, 3));
        end else if (k == 1) begin
          kind = TYPE_HEAT;
        end else begin
          kind = 8'($urandom_range(0, 255));
        end
        send_beat(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hold before any result, pass types, hold types either side of the codes
    send_beat(TYPE_HOLD_MIN, 8'd0, 8'd170);
    send_beat(TYPE_HOLD_MAX, 8'd255, 8'd85);
    send_beat(TYPE_PASS_LO, 8'd1, 8'd255);
    send_beat(TYPE_PASS_LO + 8'd1, 8'd2, 8'd0);
    send_beat(TYPE_PASS_LO + 8'd2, 8'd3, 8'd128);
    send_beat(TYPE_PASS_HI, 8'd4, 8'd127);
    send_beat(TYPE_PASS_LO - 8'd1, 8'd5, 8'd9);
    send_beat(TYPE_HEAT + 8'd1, 8'd6, 8'd9);
    // oldest reading still zero
    send_beat(TYPE_HEAT, 8'd255, 8'd255);
    send_beat(TYPE_HEAT, 8'd0, 8'd0);
    // steep rise above the hot level with saturation, then a fall
    repeat (7) send_beat(TYPE_HEAT, 8'd3, 8'd250);
    send_beat(TYPE_HEAT, 8'd3, 8'd255);
    send_beat(TYPE_HEAT, 8'd3, 8'd60);
    // steep rise below the hot level
    repeat (7) send_beat(TYPE_HEAT, 8'd9, 8'd10);
    send_beat(TYPE_HEAT, 8'd9, 8'd20);

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: write_hot_level(8'd0);
        1: write_hot_level(8'd255);
        3: write_hot_level(HOT_RESET);
        4: write_hot_level(8'd1);
        default: write_hot_level(8'($urandom_range(0, 255)));
      endcase
      case (seg / 2)
        0: begin
          in_idle_pct = 20;
          out_idle_pct = 63;
        end
        1: begin
          in_idle_pct = 63;
          out_idle_pct = 20;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase
      run_segment(240);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("[heat_detector_rate_of_rise_scaler] OK");
    end else begin
      $display("[heat_detector_rate_of_rise_scaler] ERROR");
    end
    $finish;
  end

endmodule
